>>> rtl/sva_pkg.sv
// Shared types and constants for the voice slot allocator.
// Used by sva_cell, sva_out_buf and synth_voice_allocator_core; no dependencies.
`timescale 1ns / 1ps

package sva_pkg;

  // Event op codes on the input channel.
  localparam logic [2:0] OP_NOTE_ON     = 3'd0;
  localparam logic [2:0] OP_NOTE_OFF    = 3'd1;
  localparam logic [2:0] OP_ALL_OFF     = 3'd2;
  localparam logic [2:0] OP_SUSTAIN_ON  = 3'd3;
  localparam logic [2:0] OP_SUSTAIN_OFF = 3'd4;
  localparam logic [2:0] OP_VOICE_DONE  = 3'd5;

  // Command codes on the output channel.
  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_PLAY_MODE    = 1'b0;
  localparam logic CFG_UNISON_COUNT = 1'b1;

  localparam int NoteCount  = 128;
  localparam int MaxResults = 17;

  // One voice slot as it travels around the ring.
  typedef struct packed {
    logic        active;
    logic [6:0]  note;
    logic [31:0] stamp;
  } sva_entry_t;

  // One output beat.
  typedef struct packed {
    logic       command;
    logic [3:0] slot;
    logic [6:0] note;
    logic [6:0] velocity;
    logic [2:0] unison_index;
    logic       stolen;
    logic       last;
  } sva_result_t;

  // Status of the output buffer seen by the controller.
  typedef struct packed {
    logic can_emit;
    logic pend_valid;
    logic out_free;
  } sva_buf_status_t;

endpackage

>>> rtl/synth_voice_allocator_core.sv
// Voice slot allocator top level. Slots live in a ring of cells that rotates one
// slot per cycle past a single head, except while a command beat cannot be
// placed; a pass visits all NUM_VOICES slots. Poly note-on makes unison+1
// passes; mono note-on one pass and then the slot 0 start; note-off with the
// pedal up, all-notes-off and voice-finished one pass; sustain off a pass per
// held note; other events none. One event in flight at a time.
// Reset clears all slots, the stamp counter, the pedal and the sustained notes.
`timescale 1ns / 1ps

module synth_voice_allocator_core
  import sva_pkg::*;
#(
  parameter int NUM_VOICES = 16,
  parameter int UNISON_MAX = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [3:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] in_op_i,
  input  logic [6:0] in_note_i,
  input  logic [6:0] in_velocity_i,
  input  logic [3:0] in_voice_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       out_command_o,
  output logic [3:0] out_slot_o,
  output logic [6:0] out_note_out_o,
  output logic [6:0] out_velocity_out_o,
  output logic [2:0] out_unison_index_o,
  output logic       out_stolen_o,
  output logic       out_last_o
);

  localparam int IW  = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int UCW = $clog2(UNISON_MAX + 1);
  localparam logic [IW-1:0] LastIdx = IW'(NUM_VOICES - 1);

  // Controller states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_NOTES  = 3'd2;
  localparam logic [2:0] S_MSTART = 3'd3;
  localparam logic [2:0] S_FLUSH  = 3'd4;

  // Kinds of pass over the ring.
  localparam logic [2:0] K_REL_NOTE = 3'd0;
  localparam logic [2:0] K_REL_ALL  = 3'd1;
  localparam logic [2:0] K_MONO     = 3'd2;
  localparam logic [2:0] K_POLY     = 3'd3;
  localparam logic [2:0] K_DONE     = 3'd4;

  // Configuration registers.
  logic       play_mode_q;
  logic [3:0] unison_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      play_mode_q  <= 1'b0;
      unison_cfg_q <= 4'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PLAY_MODE:    play_mode_q  <= cfg_data_i[0];
        CFG_UNISON_COUNT: unison_cfg_q <= cfg_data_i;
        default:          play_mode_q  <= play_mode_q;
      endcase
    end
  end

  // Effective unison count, clamped to 1..UNISON_MAX.
  logic [UCW-1:0] ucnt_eff;
  always_comb begin
    if (unison_cfg_q == 4'd0) begin
      ucnt_eff = UCW'(1);
    end else if (32'(unison_cfg_q) > UNISON_MAX) begin
      ucnt_eff = UCW'(UNISON_MAX);
    end else begin
      ucnt_eff = UCW'(unison_cfg_q);
    end
  end

  // Controller registers.
  logic [2:0]           state_q, state_d;
  logic [2:0]           kind_q, kind_d;
  logic [2:0]           op_q, op_d;
  logic [6:0]           note_q, note_d;
  logic [6:0]           vel_q, vel_d;
  logic [3:0]           voice_q, voice_d;
  logic [6:0]           tnote_q, tnote_d;
  logic [6:0]           nidx_q, nidx_d;
  logic [IW-1:0]        idx_q, idx_d;
  logic [UCW-1:0]       ucnt_q, ucnt_d;
  logic [UCW-1:0]       pass_q, pass_d;
  logic [IW-1:0]        tgt_q, tgt_d;
  logic [IW-1:0]        best_q, best_d;
  logic [31:0]          best_stamp_q, best_stamp_d;
  logic                 free_q, free_d;
  logic                 stl0_q, stl0_d;
  logic [31:0]          stamp_q, stamp_d;
  logic                 pedal_q, pedal_d;
  logic [NoteCount-1:0] defer_q, defer_d;
  logic [4:0]           rcnt_q, rcnt_d;

  // Ring of slot cells; cell 0 is the head, the tail takes the updated head.
  sva_entry_t ring [NUM_VOICES];
  sva_entry_t head, head_mod;
  logic       advance;

  for (genvar g = 0; g < NUM_VOICES; g++) begin : g_cell
    sva_entry_t cell_in;
    if (g == NUM_VOICES - 1) begin : g_tail
      assign cell_in = head_mod;
    end else begin : g_mid
      assign cell_in = ring[g+1];
    end
    sva_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (advance),
      .ent_i   (cell_in),
      .ent_o   (ring[g])
    );
  end

  assign head = ring[0];

  // Output buffer.
  sva_buf_status_t buf_st;
  sva_result_t     res, out_res;
  logic            emit_req, emit_fire, flush_fire, emit_room;

  sva_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_i      (emit_fire),
    .res_i       (res),
    .flush_i     (flush_fire),
    .status_o    (buf_st),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_res)
  );

  // Beats past the result limit are dropped, but the state still moves on.
  assign emit_room = (32'(rcnt_q) < MaxResults);

  logic in_fire;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;

  // Head evaluation and sequencing.
  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    op_d         = op_q;
    note_d       = note_q;
    vel_d        = vel_q;
    voice_d      = voice_q;
    tnote_d      = tnote_q;
    nidx_d       = nidx_q;
    idx_d        = idx_q;
    ucnt_d       = ucnt_q;
    pass_d       = pass_q;
    tgt_d        = tgt_q;
    best_d       = best_q;
    best_stamp_d = best_stamp_q;
    free_d       = free_q;
    stl0_d       = stl0_q;
    stamp_d      = stamp_q;
    pedal_d      = pedal_q;
    defer_d      = defer_q;
    rcnt_d       = rcnt_q;
    head_mod     = head;
    emit_req     = 1'b0;
    res          = '0;
    advance      = 1'b0;
    flush_fire   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_d    = in_op_i;
          note_d  = in_note_i;
          vel_d   = in_velocity_i;
          voice_d = in_voice_i;
          tnote_d = in_note_i;
          rcnt_d  = '0;
          idx_d   = '0;
          pass_d  = '0;
          free_d  = 1'b0;
          ucnt_d  = ucnt_eff;
          case (in_op_i)
            OP_NOTE_ON: begin
              defer_d[in_note_i] = 1'b0;
              if (play_mode_q) begin
                defer_d = '0;
                kind_d  = K_MONO;
              end else begin
                kind_d  = K_POLY;
              end
              state_d = S_SCAN;
            end
            OP_NOTE_OFF: begin
              if (pedal_q) begin
                defer_d[in_note_i] = 1'b1;
              end else begin
                kind_d  = K_REL_NOTE;
                state_d = S_SCAN;
              end
            end
            OP_ALL_OFF: begin
              defer_d = '0;
              kind_d  = K_REL_ALL;
              state_d = S_SCAN;
            end
            OP_SUSTAIN_ON: begin
              pedal_d = 1'b1;
            end
            OP_SUSTAIN_OFF: begin
              pedal_d = 1'b0;
              nidx_d  = '0;
              state_d = S_NOTES;
            end
            OP_VOICE_DONE: begin
              kind_d  = K_DONE;
              state_d = S_SCAN;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_NOTES: begin
        // Walk sustained notes upward, one note a cycle outside release passes.
        if (defer_q[nidx_q]) begin
          defer_d[nidx_q] = 1'b0;
          tnote_d = nidx_q;
          kind_d  = K_REL_NOTE;
          idx_d   = '0;
          state_d = S_SCAN;
        end else if (nidx_q == 7'(NoteCount - 1)) begin
          state_d = S_FLUSH;
        end else begin
          nidx_d = nidx_q + 7'd1;
        end
      end

      S_SCAN: begin
        case (kind_q)
          K_REL_NOTE: begin
            if (head.active && head.note == tnote_q) begin
              emit_req = 1'b1;
            end
            res.command = CMD_RELEASE;
            res.slot    = 4'(idx_q);
            res.note    = head.note;
          end
          K_REL_ALL, K_MONO: begin
            emit_req    = head.active;
            res.command = CMD_RELEASE;
            res.slot    = 4'(idx_q);
            res.note    = head.note;
            if (kind_q == K_MONO && idx_q == '0) begin
              head_mod.active = 1'b1;
              head_mod.note   = note_q;
              head_mod.stamp  = stamp_q;
            end
          end
          K_POLY: begin
            // Write the slot picked on the previous pass, then pick again.
            if (pass_q != '0 && idx_q == tgt_q) begin
              emit_req         = 1'b1;
              res.command      = CMD_START;
              res.slot         = 4'(idx_q);
              res.note         = note_q;
              res.velocity     = vel_q;
              res.unison_index = 3'(pass_q - UCW'(1));
              res.stolen       = head.active;
              head_mod.active  = 1'b1;
              head_mod.note    = note_q;
              head_mod.stamp   = stamp_q;
            end
          end
          K_DONE: begin
            if (32'(idx_q) == 32'(voice_q)) begin
              head_mod.active = 1'b0;
            end
          end
          default: begin
            emit_req = 1'b0;
          end
        endcase

        advance = !emit_req || !emit_room || buf_st.can_emit;

        if (advance) begin
          idx_d = (idx_q == LastIdx) ? '0 : idx_q + IW'(1);
          if (emit_req && emit_room) begin
            rcnt_d = rcnt_q + 5'd1;
          end
          if (kind_q == K_MONO && idx_q == '0) begin
            stl0_d  = head.active;
            stamp_d = stamp_q + 32'd1;
          end
          if (kind_q == K_POLY) begin
            if (pass_q != '0 && idx_q == tgt_q) begin
              stamp_d = stamp_q + 32'd1;
            end
            // Lowest free slot wins, else the oldest stamp, lowest slot on ties.
            if (!free_q) begin
              if (!head_mod.active) begin
                free_d = 1'b1;
                best_d = idx_q;
              end else if (idx_q == '0 || head_mod.stamp < best_stamp_q) begin
                best_d       = idx_q;
                best_stamp_d = head_mod.stamp;
              end
            end
          end

          if (idx_q == LastIdx) begin
            case (kind_q)
              K_REL_NOTE: begin
                if (op_q == OP_SUSTAIN_OFF) begin
                  if (nidx_q == 7'(NoteCount - 1)) begin
                    state_d = S_FLUSH;
                  end else begin
                    nidx_d  = nidx_q + 7'd1;
                    state_d = S_NOTES;
                  end
                end else begin
                  state_d = S_FLUSH;
                end
              end
              K_MONO: begin
                state_d = S_MSTART;
              end
              K_POLY: begin
                free_d = 1'b0;
                if (pass_q == ucnt_q) begin
                  state_d = S_FLUSH;
                end else begin
                  tgt_d  = free_d ? best_d : best_d;
                  pass_d = pass_q + UCW'(1);
                end
              end
              default: begin
                state_d = S_FLUSH;
              end
            endcase
          end
        end
      end

      S_MSTART: begin
        // Mono restart of slot 0 after all releases.
        emit_req    = 1'b1;
        res.command = CMD_START;
        res.slot    = 4'd0;
        res.note    = note_q;
        res.velocity = vel_q;
        res.stolen  = stl0_q;
        if (!emit_room || buf_st.can_emit) begin
          if (emit_room) begin
            rcnt_d = rcnt_q + 5'd1;
          end
          state_d = S_FLUSH;
        end
      end

      S_FLUSH: begin
        if (!buf_st.pend_valid) begin
          state_d = S_IDLE;
        end else if (buf_st.out_free) begin
          flush_fire = 1'b1;
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign emit_fire = emit_req && emit_room && buf_st.can_emit &&
                     (state_q == S_SCAN || state_q == S_MSTART);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q  <= K_REL_ALL;
      idx_q   <= '0;
      pass_q  <= '0;
      free_q  <= 1'b0;
      stamp_q <= '0;
      pedal_q <= 1'b0;
      defer_q <= '0;
      rcnt_q  <= '0;
      nidx_q  <= '0;
      ucnt_q  <= UCW'(1);
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      idx_q   <= idx_d;
      pass_q  <= pass_d;
      free_q  <= free_d;
      stamp_q <= stamp_d;
      pedal_q <= pedal_d;
      defer_q <= defer_d;
      rcnt_q  <= rcnt_d;
      nidx_q  <= nidx_d;
      ucnt_q  <= ucnt_d;
    end
  end

  // Event payload and search registers.
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    note_q       <= note_d;
    vel_q        <= vel_d;
    voice_q      <= voice_d;
    tnote_q      <= tnote_d;
    tgt_q        <= tgt_d;
    best_q       <= best_d;
    best_stamp_q <= best_stamp_d;
    stl0_q       <= stl0_d;
  end

  assign out_command_o      = out_res.command;
  assign out_slot_o         = out_res.slot;
  assign out_note_out_o     = out_res.note;
  assign out_velocity_out_o = out_res.velocity;
  assign out_unison_index_o = out_res.unison_index;
  assign out_stolen_o       = out_res.stolen;
  assign out_last_o         = out_res.last;

  // No beat is left pending once the block is ready for the next event.
  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !buf_st.pend_valid)
    else $error("pending beat left while idle");

  // The result count never passes the limit.
  a_result_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(rcnt_q) <= MaxResults)
    else $error("result count above limit");

  // The ring is aligned (head is slot 0) whenever an event is taken.
  a_ring_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> (idx_q == '0))
    else $error("ring not aligned at event start");

  // Entering a pass always starts at the head slot.
  a_scan_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_SCAN && state_d == S_SCAN) |=> (idx_q == '0))
    else $error("pass did not start at slot 0");

endmodule

>>> rtl/sva_cell.sv
// One cell of the voice slot ring: holds a slot and passes it to its neighbor.
// Depends on sva_pkg.
`timescale 1ns / 1ps

module sva_cell
  import sva_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       shift_i,
  input  sva_entry_t ent_i,
  output sva_entry_t ent_o
);

  sva_entry_t ent_q, ent_d;

  // Take the neighbor's slot on every ring step, hold otherwise.
  always_comb begin
    ent_d = ent_q;
    if (shift_i) begin
      ent_d = ent_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else begin
      ent_q <= ent_d;
    end
  end

  assign ent_o = ent_q;

endmodule

>>> rtl/sva_out_buf.sv
// Output stage: a pending beat plus the output register, so that the final
// beat of an event can be marked last. Depends on sva_pkg.
`timescale 1ns / 1ps

module sva_out_buf
  import sva_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            emit_i,
  input  sva_result_t     res_i,
  input  logic            flush_i,
  output sva_buf_status_t status_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output sva_result_t     out_o
);

  logic        pend_valid_q, pend_valid_d;
  sva_result_t pend_q, pend_d;
  logic        out_valid_q, out_valid_d;
  sva_result_t out_q, out_d;
  logic        out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // A new beat pushes the pending one out; a flush marks it last.
  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && out_stall_i;
    if (emit_i) begin
      if (pend_valid_q) begin
        out_d       = pend_q;
        out_d.last  = 1'b0;
        out_valid_d = 1'b1;
      end
      pend_d       = res_i;
      pend_valid_d = 1'b1;
    end else if (flush_i && pend_valid_q) begin
      out_d        = pend_q;
      out_d.last   = 1'b1;
      out_valid_d  = 1'b1;
      pend_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign status_o.can_emit   = !pend_valid_q || out_free;
  assign status_o.pend_valid = pend_valid_q;
  assign status_o.out_free   = out_free;
  assign out_valid_o         = out_valid_q;
  assign out_o               = out_q;

endmodule

>>> dv/tb_synth_voice_allocator_core.sv
// Self-checking testbench for the voice slot allocator: directed table, then random events.
// Depends on rtl/sva_pkg.sv and rtl/synth_voice_allocator_core.sv.
`timescale 1ns / 1ps

module tb_synth_voice_allocator_core;
  import sva_pkg::*;

  localparam int NumVoices = 16;
  localparam int UnisonMax = 8;
  localparam int SettleCycles = 400;
  // Codes the block must ignore.
  localparam logic [2:0] OP_RSVD_6 = 3'd6;
  localparam logic [2:0] OP_RSVD_7 = 3'd7;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic       cfg_idx_i = 1'b0;
  logic [3:0] cfg_data_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [2:0] in_op_i = '0;
  logic [6:0] in_note_i = '0;
  logic [6:0] in_velocity_i = '0;
  logic [3:0] in_voice_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       out_command_o;
  logic [3:0] out_slot_o;
  logic [6:0] out_note_out_o;
  logic [6:0] out_velocity_out_o;
  logic [2:0] out_unison_index_o;
  logic       out_stolen_o;
  logic       out_last_o;

  synth_voice_allocator_core dut (.*);

  always #5 clk_i = ~clk_i;

  // Allocator shadow state.
  logic        mode_mono;
  logic [3:0]  unison_reg;
  logic        voice_on [NumVoices];
  logic [6:0]  voice_note [NumVoices];
  logic [31:0] voice_stamp [NumVoices];
  logic [31:0] next_stamp;
  logic        pedal_down;
  logic        held_off [NoteCount];

  sva_result_t pending_cmds[$];
  sva_result_t event_cmds[$];
  int          fail_count = 0;
  bit          idle_en = 1'b1;

  function automatic void push_cmd(logic cmd, logic [3:0] s, logic [6:0] n,
                                   logic [6:0] v, logic [2:0] u, logic st);
    sva_result_t r;
    r = '{command: cmd, slot: s, note: n, velocity: v, unison_index: u,
          stolen: st, last: 1'b0};
    if (event_cmds.size() < MaxResults) event_cmds.push_back(r);
  endfunction

  function automatic void release_note_cmds(logic [6:0] n);
    for (int i = 0; i < NumVoices; i++)
      if (voice_on[i] && voice_note[i] == n)
        push_cmd(CMD_RELEASE, 4'(i), n, '0, '0, 1'b0);
  endfunction

  function automatic void release_every_voice();
    for (int i = 0; i < NumVoices; i++)
      if (voice_on[i]) push_cmd(CMD_RELEASE, 4'(i), voice_note[i], '0, '0, 1'b0);
    foreach (held_off[n]) held_off[n] = 1'b0;
  endfunction

  function automatic void start_voice(int s, logic [6:0] n, logic [6:0] v, int u);
    logic st;
    st = voice_on[s];
    voice_on[s] = 1'b1;
    voice_note[s] = n;
    voice_stamp[s] = next_stamp;
    next_stamp = next_stamp + 32'd1;
    push_cmd(CMD_START, 4'(s), n, v, 3'(u), st);
  endfunction

  // Lowest free slot, else the oldest stamp (lowest slot on a tie).
  function automatic int choose_slot();
    int pick;
    pick = 0;
    for (int i = 0; i < NumVoices; i++)
      if (!voice_on[i]) return i;
    for (int i = 1; i < NumVoices; i++)
      if (voice_stamp[i] < voice_stamp[pick]) pick = i;
    return pick;
  endfunction

  // Works out the command beats of one event and queues them.
  function automatic void predict_commands(logic [2:0] op, logic [6:0] n,
                                           logic [6:0] v, logic [3:0] vc);
    int cnt;
    event_cmds.delete();
    case (op)
      OP_NOTE_ON: begin
        held_off[n] = 1'b0;
        if (mode_mono) begin
          release_every_voice();
          start_voice(0, n, v, 0);
        end else begin
          cnt = (unison_reg == 0) ? 1 : (unison_reg > UnisonMax) ? UnisonMax : unison_reg;
          for (int u = 0; u < cnt; u++) start_voice(choose_slot(), n, v, u);
        end
      end
      OP_NOTE_OFF: begin
        if (pedal_down) held_off[n] = 1'b1;
        else release_note_cmds(n);
      end
      OP_ALL_OFF: release_every_voice();
      OP_SUSTAIN_ON: pedal_down = 1'b1;
      OP_SUSTAIN_OFF: begin
        pedal_down = 1'b0;
        for (int k = 0; k < NoteCount; k++)
          if (held_off[k]) begin
            release_note_cmds(7'(k));
            held_off[k] = 1'b0;
          end
      end
      OP_VOICE_DONE: if (vc < NumVoices) voice_on[vc] = 1'b0;
      default: ;
    endcase
    if (event_cmds.size() > 0) event_cmds[event_cmds.size() - 1].last = 1'b1;
    foreach (event_cmds[i]) pending_cmds.push_back(event_cmds[i]);
  endfunction

  // Output side: random stall, compare each accepted beat with the oldest expectation.
  always @(negedge clk_i)
    out_stall_i <= idle_en && ($urandom_range(99) < 38);

  always @(posedge clk_i) begin
    sva_result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_cmds.size() == 0) begin
        $error("unexpected beat: slot %0d note %0d", out_slot_o, out_note_out_o);
        fail_count++;
      end else begin
        exp_r = pending_cmds.pop_front();
        if (out_command_o !== exp_r.command) begin
          $error("command: expected %0d, got %0d", exp_r.command, out_command_o);
          fail_count++;
        end
        if (out_slot_o !== exp_r.slot) begin
          $error("slot: expected %0d, got %0d", exp_r.slot, out_slot_o);
          fail_count++;
        end
        if (out_note_out_o !== exp_r.note) begin
          $error("note_out: expected %0d, got %0d", exp_r.note, out_note_out_o);
          fail_count++;
        end
        if (out_velocity_out_o !== exp_r.velocity) begin
          $error("velocity_out: expected %0d, got %0d", exp_r.velocity,
                 out_velocity_out_o);
          fail_count++;
        end
        if (out_unison_index_o !== exp_r.unison_index) begin
          $error("unison_index: expected %0d, got %0d", exp_r.unison_index,
                 out_unison_index_o);
          fail_count++;
        end
        if (out_stolen_o !== exp_r.stolen) begin
          $error("stolen: expected %0d, got %0d", exp_r.stolen, out_stolen_o);
          fail_count++;
        end
        if (out_last_o !== exp_r.last) begin
          $error("last: expected %0d, got %0d", exp_r.last, out_last_o);
          fail_count++;
        end
      end
    end
  end

  // Drives one event beat; called and returns at a falling edge.
  task automatic send_event(logic [2:0] op, logic [6:0] n, logic [6:0] v, logic [3:0] vc);
    while (idle_en && $urandom_range(99) < 38) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_op_i <= op;
    in_note_i <= n;
    in_velocity_i <= v;
    in_voice_i <= vc;
    do @(posedge clk_i); while (in_stall_o);
    predict_commands(op, n, v, vc);
    @(negedge clk_i);
  endtask

  // Waits until every expected beat has come and the block has settled.
  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    while (pending_cmds.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [3:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_PLAY_MODE) mode_mono = data[0];
    else unison_reg = data;
  endtask

  // Random event biased toward well-formed play: notes on, offs of playing notes, finishes.
  task automatic send_random_event();
    int sel, s;
    logic [6:0] n;
    sel = $urandom_range(99);
    s = $urandom_range(NumVoices - 1);
    n = ($urandom_range(99) < 30) ? 7'($urandom) : 7'(40 + $urandom_range(7));
    if (sel < 32) send_event(OP_NOTE_ON, n, 7'($urandom), 4'($urandom));
    else if (sel < 57) begin
      if (voice_on[s] && $urandom_range(3) != 0) n = voice_note[s];
      send_event(OP_NOTE_OFF, n, 7'($urandom), 4'($urandom));
    end else if (sel < 80) begin
      for (int k = 0; k < NumVoices && $urandom_range(3) != 0; k++)
        if (voice_on[(s + k) % NumVoices]) begin
          s = (s + k) % NumVoices;
          break;
        end
      send_event(OP_VOICE_DONE, 7'($urandom), 7'($urandom), 4'(s));
    end else if (sel < 87) send_event(OP_SUSTAIN_ON, n, 7'($urandom), 4'($urandom));
    else if (sel < 94) send_event(OP_SUSTAIN_OFF, n, 7'($urandom), 4'($urandom));
    else if (sel < 97) send_event(OP_ALL_OFF, n, 7'($urandom), 4'($urandom));
    else send_event(($urandom_range(1) != 0) ? OP_RSVD_7 : OP_RSVD_6, n,
                    7'($urandom), 4'($urandom));
  endtask

  typedef struct {
    logic [2:0]  op;
    logic [6:0]  note;
    logic [6:0]  vel;
    logic [3:0]  voice;
    bit          typed;
    sva_result_t first;
  } stim_row_t;

  localparam sva_result_t NoBeat = '0;

  // Directed events under reset settings: poly, one voice per note.
  stim_row_t directed_rows[] = '{
    '{OP_NOTE_ON, 7'd0, 7'd127, 4'd0, 1'b1, '{CMD_START, 4'd0, 7'd0, 7'd127, 3'd0, 1'b0, 1'b1}},
    '{OP_NOTE_ON, 7'd127, 7'd0, 4'd15, 1'b1, '{CMD_START, 4'd1, 7'd127, 7'd0, 3'd0, 1'b0, 1'b1}},
    '{OP_NOTE_OFF, 7'd0, 7'd0, 4'd0, 1'b1, '{CMD_RELEASE, 4'd0, 7'd0, 7'd0, 3'd0, 1'b0, 1'b1}},
    // A released voice that has not finished is released again.
    '{OP_NOTE_OFF, 7'd0, 7'd0, 4'd0, 1'b1, '{CMD_RELEASE, 4'd0, 7'd0, 7'd0, 3'd0, 1'b0, 1'b1}},
    '{OP_VOICE_DONE, 7'd0, 7'd0, 4'd0, 1'b0, NoBeat},
    '{OP_NOTE_OFF, 7'd0, 7'd0, 4'd0, 1'b0, NoBeat},
    '{OP_SUSTAIN_ON, 7'd0, 7'd0, 4'd0, 1'b0, NoBeat},
    '{OP_NOTE_OFF, 7'd127, 7'd0, 4'd0, 1'b0, NoBeat},
    '{OP_NOTE_ON, 7'd64, 7'd85, 4'd0, 1'b0, NoBeat},
    '{OP_NOTE_OFF, 7'd64, 7'd0, 4'd0, 1'b0, NoBeat},
    // A new note-on cancels the held note-off of the same note.
    '{OP_NOTE_ON, 7'd64, 7'd42, 4'd0, 1'b0, NoBeat},
    '{OP_SUSTAIN_OFF, 7'd0, 7'd0, 4'd0, 1'b1, '{CMD_RELEASE, 4'd1, 7'd127, 7'd0, 3'd0, 1'b0, 1'b1}},
    '{OP_VOICE_DONE, 7'd0, 7'd0, 4'd15, 1'b0, NoBeat},
    '{OP_RSVD_6, 7'd127, 7'd127, 4'd15, 1'b0, NoBeat},
    '{OP_RSVD_7, 7'd0, 7'd0, 4'd0, 1'b0, NoBeat},
    '{OP_ALL_OFF, 7'd0, 7'd0, 4'd0, 1'b1, '{CMD_RELEASE, 4'd0, 7'd64, 7'd0, 3'd0, 1'b0, 1'b0}}
  };

  // Settings per random phase: play mode and unison, extremes included.
  logic [3:0] phase_mode[] = '{4'd0, 4'd0, 4'd1, 4'd0, 4'd0, 4'd1};
  logic [3:0] phase_unison[] = '{4'd15, 4'd0, 4'd8, 4'd8, 4'd3, 4'd1};

  initial begin
    mode_mono = 1'b0;
    unison_reg = 4'd1;
    next_stamp = '0;
    pedal_down = 1'b0;
    foreach (voice_on[i]) begin
      voice_on[i] = 1'b0;
      voice_note[i] = '0;
      voice_stamp[i] = '0;
    end
    foreach (held_off[n]) held_off[n] = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table; typed rows cross-check the first predicted beat.
    foreach (directed_rows[r]) begin
      send_event(directed_rows[r].op, directed_rows[r].note, directed_rows[r].vel,
                 directed_rows[r].voice);
      if (directed_rows[r].typed && (event_cmds.size() == 0 ||
                                     event_cmds[0] != directed_rows[r].first)) begin
        $error("row %0d: first beat expected %h", r, directed_rows[r].first);
        fail_count++;
      end
    end

    foreach (phase_mode[p]) begin
      drain_and_settle();
      write_reg(CFG_PLAY_MODE, phase_mode[p]);
      write_reg(CFG_UNISON_COUNT, phase_unison[p]);
      idle_en = (p != 2);
      for (int i = 0; i < 33; i++) begin
        // Hold the sender until every expected beat is out.
        if (p == 3 && i == 15) begin
          in_valid_i <= 1'b0;
          while (pending_cmds.size() != 0) @(negedge clk_i);
        end
        send_random_event();
      end
    end
    idle_en = 1'b1;

    in_valid_i <= 1'b0;
    while (pending_cmds.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    if (pending_cmds.size() == 0 && fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
